/* rtl/assert_macros.svh */
// Assertion macros used by the checker file of this block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion on the rising clock edge, off while reset is held.
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Implication checked on the rising clock edge, off while reset is held.
`define ASSERT_IMPLY(label, clk, rst_n, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
    else $error(msg);

// Next-cycle implication checked on the rising clock edge, off while reset is held.
`define ASSERT_NEXT(label, clk, rst_n, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error(msg);

`endif

/* rtl/mtrr_pkg.sv */
// Package with the types and constants of the variable-range memory type resolver.
package mtrr_pkg;

  // Memory type codes.
  localparam logic [2:0] MemTypeUc     = 3'd0;
  localparam logic [2:0] MemTypeWb     = 3'd6;
  localparam logic [2:0] MemTypeNone   = 3'd0;

  // Operation codes carried in tuser.
  localparam logic       OpLoad        = 1'b0;
  localparam logic       OpLookup      = 1'b1;

  // Field geometry of the beats.
  localparam int unsigned InFrameW     = 40;
  localparam int unsigned PageW        = 18;
  localparam int unsigned PageShift    = 9;   // 2MB page holds 512 frames of 4KB
  localparam int unsigned InTdataW     = 104;
  localparam int unsigned OutTdataW    = 8;

  // Sequencer states.
  typedef enum logic [1:0] {
    StIdle,
    StLoad,
    StScan,
    StDone
  } state_e;

endpackage

/* rtl/mtrr_memory_type_resolver.sv */
// Variable-range memory type resolver: range table in a synchronous RAM, scanned per lookup.
//
//   Channel  | Dir | Beat contents
//   s_axis   | in  | tuser: operation; tdata: base, mask, type, enabled, page
//   m_axis   | out | tdata: memory_type, range_stored, table_full
//
// A load that is not stored, and a lookup of page 0, go from acceptance straight to the done
// state, which fills the output register; a stored load first passes the load state for the
// add and write. Any other lookup scans the table: one RAM read per stored range and a test of
// the last entry read (neither with an empty table), then the done state, ending early on an
// uncacheable match. One item is worked at a time; the next beat is taken while a result waits.
// A stalled output holds the finished result and the sequencer waits in its done state.
// Reset empties the table at once; no clearing pass is needed.
module mtrr_memory_type_resolver import mtrr_pkg::*; #(
  parameter int unsigned MAX_RANGES = 16,
  parameter int unsigned FRAME_BITS = 40
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  // operation
  input  logic                 s_axis_tuser,
  // range_base_frame[39:0], range_mask_frame[79:40], range_type[82:80],
  // range_enabled[83], page_number[101:84], zero fill [103:102]
  input  logic [InTdataW-1:0]  s_axis_tdata,
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  // memory_type[2:0], range_stored[3], table_full[4], zero fill [7:5]
  output logic [OutTdataW-1:0] m_axis_tdata
);

  localparam int unsigned CntW  = $clog2(MAX_RANGES + 1);
  localparam int unsigned AddrW = (MAX_RANGES > 1) ? $clog2(MAX_RANGES) : 1;
  localparam int unsigned WideW = (FRAME_BITS > InFrameW) ? FRAME_BITS : InFrameW;
  localparam int unsigned CmpW  = (FRAME_BITS > PageW + PageShift) ?
                                  FRAME_BITS : PageW + PageShift;
  localparam int unsigned EntW  = 2 * FRAME_BITS + 3;

  // Input field unpacking.
  logic [InFrameW-1:0]   in_base;
  logic [InFrameW-1:0]   in_mask;
  logic [2:0]            in_type;
  logic                  in_en;
  logic [PageW-1:0]      in_page;
  logic [WideW-1:0]      base_w;
  logic [WideW-1:0]      mask_w;
  logic [FRAME_BITS-1:0] base_f;
  logic [FRAME_BITS-1:0] mask_f;

  assign in_base = s_axis_tdata[39:0];
  assign in_mask = s_axis_tdata[79:40];
  assign in_type = s_axis_tdata[82:80];
  assign in_en   = s_axis_tdata[83];
  assign in_page = s_axis_tdata[101:84];
  assign base_w  = WideW'(in_base);
  assign mask_w  = WideW'(in_mask);
  assign base_f  = base_w[FRAME_BITS-1:0];
  assign mask_f  = mask_w[FRAME_BITS-1:0];

  // Control and payload registers.
  state_e                state_q, state_d;
  logic [CntW-1:0]       count_q;
  logic [CntW-1:0]       idx_q;
  logic                  pend_q;
  logic                  out_valid_q;
  logic [OutTdataW-1:0]  out_data_q;
  logic [FRAME_BITS-1:0] base_q;
  logic [FRAME_BITS-1:0] span_q;
  logic [2:0]            kind_q;
  logic [PageW-1:0]      page_q;
  logic [2:0]            type_q;
  logic                  stored_q;
  logic                  full_q;

  // Range table.
  logic [EntW-1:0]       mem [MAX_RANGES];
  logic [EntW-1:0]       rd_q;
  logic [EntW-1:0]       wr_data;

  // Sequencer outputs.
  logic                  s_fire;
  logic                  out_free;
  logic                  mem_we;
  logic                  rd_issue;
  logic                  table_is_full;
  logic                  load_wanted;

  // Datapath terms.
  logic [FRAME_BITS:0]   end_sum;
  logic [FRAME_BITS-1:0] last_f;
  logic [FRAME_BITS-1:0] rd_start;
  logic [FRAME_BITS-1:0] rd_last;
  logic [2:0]            rd_kind;
  logic [CmpW-1:0]       page_first;
  logic [CmpW-1:0]       page_end;
  logic                  hit;
  logic                  uc_stop;
  logic                  scan_end;

  assign s_fire        = s_axis_tvalid && s_axis_tready;
  assign out_free      = !out_valid_q || m_axis_tready;
  assign table_is_full = (count_q == CntW'(MAX_RANGES));
  assign load_wanted   = in_en && (in_type != MemTypeWb);

  // End frame of a new range, saturated at the top frame.
  assign end_sum = {1'b0, base_q} + {1'b0, span_q};
  assign last_f  = end_sum[FRAME_BITS] ? '1 : end_sum[FRAME_BITS-1:0];
  assign wr_data = {kind_q, last_f, base_q};

  // Overlap test of the page against the entry read last cycle.
  assign rd_start   = rd_q[FRAME_BITS-1:0];
  assign rd_last    = rd_q[2*FRAME_BITS-1:FRAME_BITS];
  assign rd_kind    = rd_q[EntW-1:2*FRAME_BITS];
  assign page_first = CmpW'({page_q, {PageShift{1'b0}}});
  assign page_end   = CmpW'({page_q, {PageShift{1'b1}}});
  assign hit        = pend_q && (page_first <= CmpW'(rd_last)) &&
                      (page_end >= CmpW'(rd_start));
  assign uc_stop    = hit && (rd_kind == MemTypeUc);
  assign scan_end   = uc_stop || (!pend_q && (idx_q == count_q));

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      StIdle: begin
        if (s_fire) begin
          if (s_axis_tuser == OpLookup) begin
            state_d = (in_page == '0) ? StDone : StScan;
          end else begin
            state_d = (load_wanted && !table_is_full) ? StLoad : StDone;
          end
        end
      end
      StLoad: state_d = StDone;
      StScan: begin
        if (scan_end) begin
          state_d = StDone;
        end
      end
      StDone: begin
        if (out_free) begin
          state_d = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  // Sequencer outputs.
  always_comb begin
    s_axis_tready = (state_q == StIdle);
    mem_we        = (state_q == StLoad);
    rd_issue      = (state_q == StScan) && (idx_q != count_q) && !uc_stop;
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      count_q     <= '0;
      idx_q       <= '0;
      pend_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (mem_we) begin
        count_q <= count_q + 1'b1;
      end
      if (s_fire) begin
        idx_q  <= '0;
        pend_q <= 1'b0;
      end else if (state_q == StScan) begin
        pend_q <= rd_issue;
        if (rd_issue) begin
          idx_q <= idx_q + 1'b1;
        end
      end
      if (state_q == StDone && out_free) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Item payload and result fields.
  always_ff @(posedge clk_i) begin
    if (s_fire) begin
      base_q   <= base_f;
      span_q   <= ~mask_f & (mask_f - 1'b1);
      kind_q   <= in_type;
      page_q   <= in_page;
      stored_q <= 1'b0;
      full_q   <= (s_axis_tuser == OpLoad) && load_wanted && table_is_full;
      if (s_axis_tuser == OpLookup) begin
        type_q <= (in_page == '0) ? MemTypeUc : MemTypeWb;
      end else begin
        type_q <= MemTypeNone;
      end
    end else if (mem_we) begin
      stored_q <= 1'b1;
    end else if (hit) begin
      type_q <= rd_kind;
    end
    if (state_q == StDone && out_free) begin
      out_data_q <= OutTdataW'({full_q, stored_q, type_q});
    end
  end

  // Range table RAM, one write and one registered read port.
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[count_q[AddrW-1:0]] <= wr_data;
    end
    if (rd_issue) begin
      rd_q <= mem[idx_q[AddrW-1:0]];
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

endmodule

/* rtl/mtrr_checker.sv */
// Port-level checker for the memory type resolver, bound to the top level.
`include "assert_macros.svh"

module mtrr_checker import mtrr_pkg::*; (
  input logic                 clk_i,
  input logic                 rst_ni,
  input logic                 s_axis_tvalid,
  input logic                 s_axis_tready,
  input logic                 m_axis_tvalid,
  input logic                 m_axis_tready,
  input logic [OutTdataW-1:0] m_axis_tdata
);

  // A load result never claims both a stored range and a full table.
  `ASSERT_IMPLY(a_stored_xor_full, clk_i, rst_ni, m_axis_tvalid, !(m_axis_tdata[3] && m_axis_tdata[4]), "range stored and table full together")

  // A nonzero memory type only comes from a lookup, which sets no load flags.
  `ASSERT_IMPLY(a_type_no_flags, clk_i, rst_ni, m_axis_tvalid && (m_axis_tdata[2:0] != MemTypeNone), m_axis_tdata[4:3] == 2'b00, "lookup result carries load flags")

  // One item at a time: the input closes right after a beat is taken.
  `ASSERT_NEXT(a_one_in_flight, clk_i, rst_ni, s_axis_tvalid && s_axis_tready, !s_axis_tready, "input ready right after an accepted beat")

  // A result offered and not taken stays offered.
  `ASSERT_NEXT(a_out_hold, clk_i, rst_ni, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata), "stalled result dropped or changed")

endmodule

bind mtrr_memory_type_resolver mtrr_checker u_mtrr_checker (.*);
